@@ rtl/core/dsml_pkg.sv @@
package dsml_pkg;

    localparam int NUM_ENTRIES    = 16;
    localparam int CALLSIGN_CHARS = 8;

    localparam int IDX_W    = 6;
    localparam int SLOT_W   = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int COUNT_W  = 7;
    localparam int ID_W     = 16;
    localparam int CALL_W   = 64;
    localparam int TTL_W    = 8;
    localparam int TAG_W    = 16;

    localparam logic [CALL_W-1:0] DEFAULT_CALLSIGN = 64'h0000_0000_314B_5655;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_MARK   = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef struct packed {
        logic              used;
        logic              unread;
        logic [ID_W-1:0]   msg_id;
        logic [CALL_W-1:0] sender;
        logic [TTL_W-1:0]  ttl_first;
        logic [TTL_W-1:0]  ttl_left;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    // Control broadcast from the top level to every cell in the chain.
    typedef struct packed {
        logic              key_ok;
        logic [ID_W-1:0]   key_id;
        logic [CALL_W-1:0] key_sender;
        logic              shift_in;
        logic              close_gap;
        logic              mark_read;
        logic [IDX_W-1:0]  idx;
    } t_cell_ctrl;

    // Keeps the bytes up to the first zero byte, at most CALLSIGN_CHARS of them.
    function automatic logic [CALL_W-1:0] trim_call(input logic [CALL_W-1:0] s);
        logic [CALL_W-1:0] r;
        logic              stop;
        r    = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (i >= CALLSIGN_CHARS || s[8*i +: 8] == 8'h00) begin
                stop = 1'b1;
            end
            if (!stop) begin
                r[8*i +: 8] = s[8*i +: 8];
            end
        end
        return r;
    endfunction

    localparam logic [CALL_W-1:0] DEFAULT_TRIMMED = trim_call(DEFAULT_CALLSIGN);

    function automatic logic [CALL_W-1:0] norm_call(input logic [CALL_W-1:0] s);
        logic [CALL_W-1:0] r;
        r = trim_call(s);
        if (r == '0) begin
            r = DEFAULT_TRIMMED;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/dsml_cell.sv @@
module dsml_cell import dsml_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_pos,
    input  t_cell_ctrl       i_ctrl,
    input  t_entry           i_prev,
    input  t_entry           i_next,
    output t_entry           o_entry,
    output logic             o_match,
    output logic             o_nxt_unread
);

    t_entry r_entry;
    t_entry n_entry;

    assign o_entry = r_entry;
    assign o_match = i_ctrl.key_ok && r_entry.used && (r_entry.msg_id == i_ctrl.key_id) &&
                     (r_entry.sender == i_ctrl.key_sender);

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.shift_in) begin
            n_entry = i_prev;
        end else if (i_ctrl.close_gap && (i_pos >= i_ctrl.idx)) begin
            n_entry = i_next;
        end else if (i_ctrl.mark_read && (i_pos == i_ctrl.idx)) begin
            n_entry.unread = 1'b0;
        end
    end

    assign o_nxt_unread = n_entry.used & n_entry.unread;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

endmodule

@@ rtl/core/dedup_shift_message_list_unit.sv @@
// Newest-first message list with duplicate suppression, built as a chain of
// cells that each hold one entry and pass it to a neighbour on add or delete.
// One transaction is taken per clock cycle: every operation finishes in the
// cycle it is accepted, and the result register frees the input as soon as
// the previous result is taken, so the input stalls only while the output
// stalls. The list is cleared by reset itself and needs no clearing pass.
module dedup_shift_message_list_unit import dsml_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_op,
    input  logic [IDX_W-1:0]   i_slot_index,
    input  logic [ID_W-1:0]    i_msg_id,
    input  logic [CALL_W-1:0]  i_sender,
    input  logic [TTL_W-1:0]   i_ttl_first,
    input  logic [TTL_W-1:0]   i_ttl_left,
    input  logic               i_unread_flag,
    input  logic [TAG_W-1:0]   i_payload_tag,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_accepted,
    output logic               o_duplicate,
    output logic               o_beep_request,
    output logic               o_slot_used,
    output logic               o_slot_unread,
    output logic [ID_W-1:0]    o_slot_msg_id,
    output logic [CALL_W-1:0]  o_slot_sender,
    output logic [TTL_W-1:0]   o_slot_ttl_first,
    output logic [TTL_W-1:0]   o_slot_ttl_left,
    output logic [TAG_W-1:0]   o_slot_payload_tag,
    output logic [COUNT_W-1:0] o_stored_count,
    output logic               o_any_unread
);

    t_entry     w_entry    [NUM_ENTRIES];
    t_entry     w_prev     [NUM_ENTRIES];
    t_entry     w_next     [NUM_ENTRIES];
    logic       w_match    [NUM_ENTRIES];
    logic       w_nxt_unr  [NUM_ENTRIES];
    t_cell_ctrl w_ctrl;
    t_entry     w_new;
    t_entry     w_sel;
    t_op        w_op;

    logic               w_take;
    logic               w_in_range;
    logic               w_dup;
    logic               w_add_ok;
    logic               w_del_hit;
    logic               w_any;
    logic [CALL_W-1:0]  w_sender;
    logic [COUNT_W-1:0] n_count;

    logic               r_beep_en;
    logic [COUNT_W-1:0] r_count;
    logic               r_out_valid;
    logic               r_accepted;
    logic               r_duplicate;
    logic               r_beep;
    t_entry             r_slot;
    logic [COUNT_W-1:0] r_stored;
    logic               r_any;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign w_take      = i_in_valid & ~o_in_stall;
    assign w_op        = t_op'(i_op);
    assign w_sender    = norm_call(i_sender);
    assign w_in_range  = ({1'b0, i_slot_index} < (IDX_W + 1)'(NUM_ENTRIES));
    assign w_sel       = w_entry[i_slot_index[SLOT_W-1:0]];

    always_comb begin
        w_dup = 1'b0;
        w_any = 1'b0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            w_dup = w_dup | w_match[i];
            w_any = w_any | w_nxt_unr[i];
        end
    end

    assign w_add_ok  = w_take && (w_op == OP_ADD) && !w_dup;
    assign w_del_hit = w_take && (w_op == OP_DELETE) && w_in_range && w_sel.used;

    always_comb begin
        w_new.used      = 1'b1;
        w_new.unread    = i_unread_flag;
        w_new.msg_id    = i_msg_id;
        w_new.sender    = w_sender;
        w_new.ttl_first = i_ttl_first;
        w_new.ttl_left  = i_ttl_left;
        w_new.tag       = i_payload_tag;
    end

    always_comb begin
        w_ctrl.key_ok     = (i_msg_id != '0);
        w_ctrl.key_id     = i_msg_id;
        w_ctrl.key_sender = w_sender;
        w_ctrl.shift_in   = w_add_ok;
        w_ctrl.close_gap  = w_del_hit;
        w_ctrl.mark_read  = w_take && (w_op == OP_MARK);
        w_ctrl.idx        = i_slot_index;
    end

    always_comb begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            w_prev[i] = (i == 0) ? w_new : w_entry[(i == 0) ? 0 : i - 1];
            w_next[i] = (i == NUM_ENTRIES - 1) ? t_entry'('0)
                                               : w_entry[(i == NUM_ENTRIES - 1) ? i : i + 1];
        end
    end

    for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
        dsml_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_pos        (IDX_W'(g)),
            .i_ctrl       (w_ctrl),
            .i_prev       (w_prev[g]),
            .i_next       (w_next[g]),
            .o_entry      (w_entry[g]),
            .o_match      (w_match[g]),
            .o_nxt_unread (w_nxt_unr[g])
        );
    end

    // The oldest entry falls off on an add, so the count grows only if it was free.
    always_comb begin
        n_count = r_count;
        if (w_add_ok && !w_entry[NUM_ENTRIES-1].used) begin
            n_count = r_count + COUNT_W'(1);
        end else if (w_del_hit) begin
            n_count = r_count - COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beep_en   <= 1'b1;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_beep_en <= i_cfg_data;
            end
            r_count <= n_count;
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_accepted  <= w_add_ok;
            r_duplicate <= (w_op == OP_ADD) && w_dup;
            r_beep      <= w_add_ok && i_unread_flag && r_beep_en;
            r_slot      <= ((w_op == OP_READ) && w_in_range) ? w_sel : t_entry'('0);
            r_stored    <= n_count;
            r_any       <= w_any;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_accepted         = r_accepted;
    assign o_duplicate        = r_duplicate;
    assign o_beep_request     = r_beep;
    assign o_slot_used        = r_slot.used;
    assign o_slot_unread      = r_slot.unread;
    assign o_slot_msg_id      = r_slot.msg_id;
    assign o_slot_sender      = r_slot.sender;
    assign o_slot_ttl_first   = r_slot.ttl_first;
    assign o_slot_ttl_left    = r_slot.ttl_left;
    assign o_slot_payload_tag = r_slot.tag;
    assign o_stored_count     = r_stored;
    assign o_any_unread       = r_any;

endmodule

@@ tb/sv/tb_dedup_shift_message_list_unit.sv @@
`timescale 1ns / 100ps

module tb_dedup_shift_message_list_unit;
    import dsml_pkg::*;

    localparam int RESET_CYCLES = 10;
    localparam int STALL_LIMIT  = 1000;
    localparam int PHASE_ITEMS  = 200;

    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  idx;
        logic [ID_W-1:0]   msg_id;
        logic [CALL_W-1:0] sender;
        logic [TTL_W-1:0]  ttl_first;
        logic [TTL_W-1:0]  ttl_left;
        logic              unread;
        logic [TAG_W-1:0]  tag;
    } list_request_t;

    typedef struct packed {
        logic               accepted;
        logic               duplicate;
        logic               beep;
        logic               used;
        logic               unread;
        logic [ID_W-1:0]    msg_id;
        logic [CALL_W-1:0]  sender;
        logic [TTL_W-1:0]   ttl_first;
        logic [TTL_W-1:0]   ttl_left;
        logic [TAG_W-1:0]   tag;
        logic [COUNT_W-1:0] count;
        logic               any_unread;
    } list_reply_t;

    // Keeps its own copy of the message list and predicts the reply to each transaction.
    class msg_list_scoreboard;
        t_entry      slots[NUM_ENTRIES];
        bit          beep_on;
        list_reply_t replies_due[$];
        int unsigned errors;

        function new();
            foreach (slots[i]) slots[i] = '0;
            beep_on = 1'b1;
            errors  = 0;
        endfunction

        function void set_beep(bit v);
            beep_on = v;
        endfunction

        function logic [CALL_W-1:0] clip_call(logic [CALL_W-1:0] s);
            logic [CALL_W-1:0] r;
            int                k;
            r = '0;
            k = 0;
            while (k < CALLSIGN_CHARS && k < 8 && s[8*k +: 8] != 8'h00) begin
                r[8*k +: 8] = s[8*k +: 8];
                k++;
            end
            return r;
        endfunction

        function logic [CALL_W-1:0] station_of(logic [CALL_W-1:0] s);
            logic [CALL_W-1:0] r;
            r = clip_call(s);
            if (r == '0) begin
                r = clip_call(DEFAULT_CALLSIGN);
            end
            return r;
        endfunction

        function void take_request(list_request_t rq);
            list_reply_t       rs;
            logic [CALL_W-1:0] call;
            bit                dup;
            int                n;
            rs   = '0;
            call = station_of(rq.sender);
            dup  = 1'b0;
            case (rq.op)
                OP_ADD: begin
                    if (rq.msg_id != '0) begin
                        foreach (slots[i]) begin
                            if (slots[i].used && slots[i].msg_id == rq.msg_id &&
                                slots[i].sender == call) dup = 1'b1;
                        end
                    end
                    if (dup) begin
                        rs.duplicate = 1'b1;
                    end else begin
                        for (int i = NUM_ENTRIES - 1; i > 0; i--) slots[i] = slots[i-1];
                        slots[0].used      = 1'b1;
                        slots[0].unread    = rq.unread;
                        slots[0].msg_id    = rq.msg_id;
                        slots[0].sender    = call;
                        slots[0].ttl_first = rq.ttl_first;
                        slots[0].ttl_left  = rq.ttl_left;
                        slots[0].tag       = rq.tag;
                        rs.accepted = 1'b1;
                        rs.beep     = rq.unread && beep_on;
                    end
                end
                OP_DELETE: begin
                    if (rq.idx < NUM_ENTRIES && slots[rq.idx].used) begin
                        for (int i = rq.idx; i < NUM_ENTRIES - 1; i++) slots[i] = slots[i+1];
                        slots[NUM_ENTRIES-1] = '0;
                    end
                end
                OP_MARK: begin
                    if (rq.idx < NUM_ENTRIES) slots[rq.idx].unread = 1'b0;
                end
                default: begin
                    if (rq.idx < NUM_ENTRIES) begin
                        rs.used      = slots[rq.idx].used;
                        rs.unread    = slots[rq.idx].unread;
                        rs.msg_id    = slots[rq.idx].msg_id;
                        rs.sender    = slots[rq.idx].sender;
                        rs.ttl_first = slots[rq.idx].ttl_first;
                        rs.ttl_left  = slots[rq.idx].ttl_left;
                        rs.tag       = slots[rq.idx].tag;
                    end
                end
            endcase
            n = 0;
            foreach (slots[i]) begin
                if (slots[i].used) begin
                    n++;
                    if (slots[i].unread) rs.any_unread = 1'b1;
                end
            end
            rs.count = COUNT_W'(n);
            replies_due.push_back(rs);
        endfunction

        function int differ(string field, logic [CALL_W-1:0] want, logic [CALL_W-1:0] got);
            if (want === got) return 0;
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            return 1;
        endfunction

        function void check_reply(list_reply_t got);
            list_reply_t want;
            if (replies_due.size() == 0) begin
                $display("%0t: reply arrived with no transaction outstanding", $time);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            errors += differ("accepted", CALL_W'(want.accepted), CALL_W'(got.accepted));
            errors += differ("duplicate", CALL_W'(want.duplicate), CALL_W'(got.duplicate));
            errors += differ("beep_request", CALL_W'(want.beep), CALL_W'(got.beep));
            errors += differ("slot_used", CALL_W'(want.used), CALL_W'(got.used));
            errors += differ("slot_unread", CALL_W'(want.unread), CALL_W'(got.unread));
            errors += differ("slot_msg_id", CALL_W'(want.msg_id), CALL_W'(got.msg_id));
            errors += differ("slot_sender", want.sender, got.sender);
            errors += differ("slot_ttl_first", CALL_W'(want.ttl_first),
                             CALL_W'(got.ttl_first));
            errors += differ("slot_ttl_left", CALL_W'(want.ttl_left), CALL_W'(got.ttl_left));
            errors += differ("slot_payload_tag", CALL_W'(want.tag), CALL_W'(got.tag));
            errors += differ("stored_count", CALL_W'(want.count), CALL_W'(got.count));
            errors += differ("any_unread", CALL_W'(want.any_unread), CALL_W'(got.any_unread));
        endfunction
    endclass

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic          i_cfg_valid = 1'b0;
    logic          i_cfg_data  = 1'b0;
    logic          i_out_stall = 1'b0;
    list_request_t cur_req     = '0;

    logic               o_in_stall;
    logic               o_cfg_ready;
    logic               o_out_valid;
    logic               o_accepted;
    logic               o_duplicate;
    logic               o_beep_request;
    logic               o_slot_used;
    logic               o_slot_unread;
    logic [ID_W-1:0]    o_slot_msg_id;
    logic [CALL_W-1:0]  o_slot_sender;
    logic [TTL_W-1:0]   o_slot_ttl_first;
    logic [TTL_W-1:0]   o_slot_ttl_left;
    logic [TAG_W-1:0]   o_slot_payload_tag;
    logic [COUNT_W-1:0] o_stored_count;
    logic               o_any_unread;

    msg_list_scoreboard board = new();
    int                 sender_idle_pct = 0;
    int                 stall_pct       = 0;
    int                 quiet_cycles    = 0;

    dedup_shift_message_list_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_op               (cur_req.op),
        .i_slot_index       (cur_req.idx),
        .i_msg_id           (cur_req.msg_id),
        .i_sender           (cur_req.sender),
        .i_ttl_first        (cur_req.ttl_first),
        .i_ttl_left         (cur_req.ttl_left),
        .i_unread_flag      (cur_req.unread),
        .i_payload_tag      (cur_req.tag),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_accepted         (o_accepted),
        .o_duplicate        (o_duplicate),
        .o_beep_request     (o_beep_request),
        .o_slot_used        (o_slot_used),
        .o_slot_unread      (o_slot_unread),
        .o_slot_msg_id      (o_slot_msg_id),
        .o_slot_sender      (o_slot_sender),
        .o_slot_ttl_first   (o_slot_ttl_first),
        .o_slot_ttl_left    (o_slot_ttl_left),
        .o_slot_payload_tag (o_slot_payload_tag),
        .o_stored_count     (o_stored_count),
        .o_any_unread       (o_any_unread)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : watch_replies
        list_reply_t seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.accepted   = o_accepted;
            seen.duplicate  = o_duplicate;
            seen.beep       = o_beep_request;
            seen.used       = o_slot_used;
            seen.unread     = o_slot_unread;
            seen.msg_id     = o_slot_msg_id;
            seen.sender     = o_slot_sender;
            seen.ttl_first  = o_slot_ttl_first;
            seen.ttl_left   = o_slot_ttl_left;
            seen.tag        = o_slot_payload_tag;
            seen.count      = o_stored_count;
            seen.any_unread = o_any_unread;
            board.check_reply(seen);
        end
    end

    // Any transaction on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input list_request_t rq);
        cur_req    <= rq;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        board.take_request(rq);
    endtask

    task automatic send_op(input t_op op, input logic [IDX_W-1:0] idx,
                           input logic [ID_W-1:0] id, input logic [CALL_W-1:0] snd,
                           input logic [TTL_W-1:0] tf, input logic [TTL_W-1:0] tl,
                           input logic un, input logic [TAG_W-1:0] tag);
        list_request_t rq;
        rq.op        = op;
        rq.idx       = idx;
        rq.msg_id    = id;
        rq.sender    = snd;
        rq.ttl_first = tf;
        rq.ttl_left  = tl;
        rq.unread    = un;
        rq.tag       = tag;
        send_request(rq);
    endtask

    task automatic pause_sender();
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    task automatic write_beep(input bit v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_beep(v);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_replies();
        i_in_valid <= 1'b0;
        while (board.replies_due.size() != 0) @(posedge i_clk);
    endtask

    // A small pool of identifiers and callsigns keeps duplicates frequent, while
    // occasional full-width values exercise every bit of every field.
    function automatic list_request_t random_request();
        list_request_t r;
        int            pick;
        r    = '0;
        pick = $urandom_range(99);
        if (pick < 40)      r.op = OP_ADD;
        else if (pick < 55) r.op = OP_DELETE;
        else if (pick < 70) r.op = OP_MARK;
        else                r.op = OP_READ;
        if ($urandom_range(3) == 0) r.idx = IDX_W'($urandom_range(63));
        else                        r.idx = IDX_W'($urandom_range(NUM_ENTRIES + 1));
        case ($urandom_range(7))
            0:       r.msg_id = '0;
            1:       r.msg_id = ID_W'($urandom);
            default: r.msg_id = ID_W'($urandom_range(6, 1));
        endcase
        case ($urandom_range(5))
            0:       r.sender = '0;
            1:       r.sender = {$urandom, $urandom};
            2:       r.sender = 64'h0000_0000_4B4F_4C41;
            3:       r.sender = {$urandom, 8'h00, 24'h324143};
            4:       r.sender = 64'h0000_0000_0032_4143;
            default: r.sender = {$urandom, $urandom} & ~64'hFF;
        endcase
        r.ttl_first = TTL_W'($urandom_range(255));
        r.ttl_left  = TTL_W'($urandom_range(255));
        r.unread    = 1'($urandom_range(1));
        r.tag       = TAG_W'($urandom);
        return r;
    endfunction

    initial begin
        int idle_set[4]  = '{0, 50, 0, 13};
        int stall_set[4] = '{0, 0, 50, 13};
        bit beep_set[4]  = '{1'b0, 1'b1, 1'b0, 1'b1};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, run with the reset value of beep_enable.
        send_op(OP_READ,   0,  16'h0000, 64'h0, 8'h00, 8'h00, 1'b0, 16'h0000);
        send_op(OP_ADD,    0,  16'h0000, 64'h0, 8'hFF, 8'h00, 1'b1, 16'hFFFF);
        send_op(OP_ADD,    63, 16'h0000, 64'h0, 8'h00, 8'hFF, 1'b0, 16'h0000);
        send_op(OP_ADD,    0,  16'hFFFF, '1,    8'hA5, 8'h5A, 1'b0, 16'h1234);
        send_op(OP_ADD,    0,  16'hFFFF, '1,    8'h01, 8'h02, 1'b1, 16'h4321);
        send_op(OP_ADD,    0,  16'h0005, 64'hAA55_0000_0000_4142, 8'h10, 8'h0F, 1'b1, 16'h0505);
        send_op(OP_ADD,    0,  16'h0005, 64'h0000_0000_0000_4142, 8'h20, 8'h1F, 1'b1, 16'h5050);
        send_op(OP_ADD,    0,  16'h0007, 64'h0, 8'h07, 8'h07, 1'b1, 16'h0707);
        send_op(OP_ADD,    0,  16'h0007, 64'hFFFF_FFFF_FFFF_FF00, 8'h00, 8'h00, 1'b0, 16'h0);
        send_op(OP_ADD,    0,  16'h0007, DEFAULT_CALLSIGN, 8'h00, 8'h00, 1'b0, 16'h0);
        send_op(OP_READ,   0,  16'h0000, 64'h0, 8'h00, 8'h00, 1'b0, 16'h0);
        send_op(OP_READ,   1,  16'hFFFF, '1,    8'hFF, 8'hFF, 1'b1, 16'hFFFF);
        send_op(OP_READ,   63, 16'h0000, 64'h0, 8'h00, 8'h00, 1'b0, 16'h0);
        send_op(OP_READ,   16, 16'h0000, 64'h0, 8'h00, 8'h00, 1'b0, 16'h0);
        send_op(OP_MARK,   0,  16'h0000, 64'h0, 8'h00, 8'h00, 1'b0, 16'h0);
        send_op(OP_MARK,   20, 16'h0000, 64'h0, 8'h00, 8'h00, 1'b0, 16'h0);
        send_op(OP_MARK,   15, 16'h0000, 64'h0, 8'h00, 8'h00, 1'b0, 16'h0);
        send_op(OP_DELETE, 15, 16'h0000, 64'h0, 8'h00, 8'h00, 1'b0, 16'h0);
        send_op(OP_DELETE, 63, 16'h0000, 64'h0, 8'h00, 8'h00, 1'b0, 16'h0);
        send_op(OP_DELETE, 1,  16'h0000, 64'h0, 8'h00, 8'h00, 1'b0, 16'h0);
        send_op(OP_READ,   1,  16'h0000, 64'h0, 8'h00, 8'h00, 1'b0, 16'h0);
        send_op(OP_READ,   15, 16'h0000, 64'h0, 8'h00, 8'h00, 1'b0, 16'h0);
        drain_replies();

        // Random part: each phase changes the idling pattern and the beep setting.
        for (int p = 0; p < 4; p++) begin
            write_beep(beep_set[p]);
            sender_idle_pct = idle_set[p];
            stall_pct       = stall_set[p];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pause_sender();
                send_request(random_request());
            end
            drain_replies();
        end

        stall_pct = 0;
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.replies_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
